@@ hdl/isotp_receive_reassembler_top_assert.svh @@
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_TOP_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ISOTP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("isotp assertion failed");
`define ISOTP_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("isotp implication failed");
`define ISOTP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("isotp next-cycle check failed");
`else
`define ISOTP_ASSERT(name, prop)
`define ISOTP_ASSERT_IMPL(name, pre, post)
`define ISOTP_ASSERT_NEXT(name, pre, post)
`endif

`endif

@@ hdl/isotp_pkg.sv @@
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler package
// Shared constants, codes and types of the reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int LANES        = 7;
  localparam int CNT_W        = $clog2(LANES + 1);
  localparam int TOT_W        = $clog2(LANES + 3);
  localparam int IDX_W        = 9;
  localparam int LINES_W      = 10;
  localparam int LEN_W        = 12;
  localparam int REM_W        = 12;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
  localparam int TICK_W       = 16;
  localparam int BS_W         = 8;
  localparam int ID_W         = 11;
  localparam int PADDR_W      = 4;
  localparam int LINE_SHIFT   = 16;

  localparam logic [POS_W-1:0]   POS_LIMIT   = POS_W'(BUFFER_BYTES - 6);
  localparam logic [POS_W-1:0]   FRAME_STEP  = POS_W'(7);
  localparam logic [LEN_W-1:0]   FIRST_BYTES = LEN_W'(6);
  localparam logic [13:0]        LINE_RECIP  = 14'd9363;
  localparam logic [LINES_W-1:0] ONE_LINE    = LINES_W'(1);

  localparam logic [3:0] PCI_FIRST    = 4'h1;
  localparam logic [3:0] PCI_CONSEC   = 4'h2;
  localparam logic [7:0] PCI_SINGLE   = 8'h10;
  localparam logic [7:0] NEG_RESPONSE = 8'h7F;

  localparam logic [1:0] REG_RESPONSE_ID = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  localparam logic [ID_W-1:0]   RESET_RESPONSE_ID = ID_W'(2031);
  localparam logic [BS_W-1:0]   RESET_BLOCK_SIZE  = BS_W'(8);
  localparam logic [TICK_W-1:0] RESET_TIMEOUT     = TICK_W'(1000);

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_FLOW    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_START = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_CONSEC = 2'd2
  } phase_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       val;
  } lane_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic [1:0]         tails;
    kind_e              tail0;
    kind_e              tail1;
    logic [LINES_W-1:0] lines;
  } job_t;

  typedef struct packed {
    logic active;
    logic last;
  } merge_st_t;

  function automatic logic [LINES_W-1:0] line_count(input logic [LEN_W-1:0] len);
    logic [LEN_W:0]    y;
    logic [LEN_W+14:0] prod;
    y    = {1'b0, len} + (LEN_W+1)'(7);
    prod = (LEN_W+15)'(y) * (LEN_W+15)'(LINE_RECIP);
    return prod[LINE_SHIFT +: LINES_W];
  endfunction

endpackage

@@ hdl/isotp_receive_reassembler_top.sv @@
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler
// Rebuilds one diagnostic response from received CAN frames, emitting byte
// writes, flow control requests and completion or timeout reports.
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  mode, can_id, frame_length, pci, payload_1..7
//   out      out_valid_o/out_ready_i kind, byte_index, byte_value, line_count, last
//   cfg      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A word with results holds the output stage until its last result leaves; a
// word with no result loads nothing. Seven byte lanes decode the payload in the
// accept cycle; the merge stage hands out one result per cycle while out_ready_i
// is high, up to nine results per word. A new word is taken in the cycle the
// last result leaves. Async reset clears the transfer and presets the registers.
// ----------------------------------------------------------------------------
module isotp_receive_reassembler_top import isotp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [ID_W-1:0]    can_id_i,
  input  logic [3:0]         frame_length_i,
  input  logic [7:0]         pci_byte_i,
  input  logic [7:0]         payload_1_i,
  input  logic [7:0]         payload_2_i,
  input  logic [7:0]         payload_3_i,
  input  logic [7:0]         payload_4_i,
  input  logic [7:0]         payload_5_i,
  input  logic [7:0]         payload_6_i,
  input  logic [7:0]         payload_7_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [IDX_W-1:0]   byte_index_o,
  output logic [7:0]         byte_value_o,
  output logic [LINES_W-1:0] line_count_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [ID_W-1:0]   resp_id_q;
  logic [BS_W-1:0]   block_size_q;
  logic [TICK_W-1:0] timeout_q;

  phase_e            phase_q, phase_d;
  logic [REM_W-1:0]  remaining_q, remaining_d;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [BS_W-1:0]   fib_q, fib_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic [LEN_W-1:0]  total_q, total_d;

  merge_st_t         merge_st;
  job_t              job;
  lane_t             lanes [LANES];
  logic [7:0]        payload [LANES];
  logic [CNT_W-1:0]  lane_cnt;
  logic [IDX_W-1:0]  lane_base;
  logic              accept;
  logic              load;
  logic              cfg_write;

  logic [CNT_W-1:0]   byte_n;
  logic [CNT_W-1:0]   used;
  logic [REM_W-1:0]   rem_sub;
  logic [BS_W-1:0]    blk_cnt;
  logic               blk_hit;
  logic [TICK_W-1:0]  elapsed_inc;
  logic [TICK_W-1:0]  tick_lim;
  logic [LEN_W-1:0]   first_len;
  logic [LINES_W-1:0] lines_total;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_id_q    <= RESET_RESPONSE_ID;
      block_size_q <= RESET_BLOCK_SIZE;
      timeout_q    <= RESET_TIMEOUT;
    end else if (cfg_write) begin
      if (paddr[3:2] == REG_RESPONSE_ID) resp_id_q    <= pwdata[ID_W-1:0];
      if (paddr[3:2] == REG_BLOCK_SIZE)  block_size_q <= pwdata[BS_W-1:0];
      if (paddr[3:2] == REG_TIMEOUT)     timeout_q    <= pwdata[TICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == REG_RESPONSE_ID) prdata = 32'(resp_id_q);
    if (paddr[3:2] == REG_BLOCK_SIZE)  prdata = 32'(block_size_q);
    if (paddr[3:2] == REG_TIMEOUT)     prdata = 32'(timeout_q);
  end

  // byte lanes
  assign payload[0] = payload_1_i;
  assign payload[1] = payload_2_i;
  assign payload[2] = payload_3_i;
  assign payload[3] = payload_4_i;
  assign payload[4] = payload_5_i;
  assign payload[5] = payload_6_i;
  assign payload[6] = payload_7_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    isotp_byte_lane u_lane (
      .lane_num_i (CNT_W'(g)),
      .count_i    (lane_cnt),
      .base_i     (lane_base),
      .byte_i     (payload[g]),
      .lane_o     (lanes[g])
    );
  end

  // frame decode helpers
  assign byte_n      = (frame_length_i > 4'd7) ? CNT_W'(7) : frame_length_i[CNT_W-1:0];
  assign used        = (frame_length_i > 4'd8) ? CNT_W'(7) :
                       (frame_length_i == 4'd0) ? CNT_W'(0) :
                       CNT_W'(frame_length_i - 4'd1);
  assign rem_sub     = (remaining_q > REM_W'(used)) ? remaining_q - REM_W'(used) : '0;
  assign blk_cnt     = fib_q + BS_W'(1);
  assign blk_hit     = (block_size_q == '0) ? (blk_cnt == '0) : (blk_cnt >= block_size_q);
  assign elapsed_inc = elapsed_q + TICK_W'(1);
  assign tick_lim    = (timeout_q == '0) ? TICK_W'(1) : timeout_q;
  assign first_len   = {pci_byte_i[3:0], payload_1_i};
  assign lines_total = line_count(total_q);

  assign in_ready_o = !merge_st.active || (out_ready_i && merge_st.last);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    wpos_d      = wpos_q;
    fib_d       = fib_q;
    elapsed_d   = elapsed_q;
    total_d     = total_q;
    lane_cnt    = '0;
    lane_base   = '0;
    job.tails   = 2'd0;
    job.tail0   = KIND_FLOW;
    job.tail1   = KIND_DONE;
    job.lines   = '0;
    if (accept) begin
      unique case (mode_e'(mode_i))
        MODE_START: begin
          phase_d     = PH_FIRST;
          remaining_d = '0;
          wpos_d      = '0;
          fib_d       = '0;
          elapsed_d   = '0;
          total_d     = '0;
        end
        MODE_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= tick_lim) begin
              job.tails = 2'd1;
              job.tail0 = KIND_TIMEOUT;
              phase_d   = PH_IDLE;
            end
          end
        end
        MODE_FRAME: begin
          if (can_id_i == resp_id_q) begin
            priority if (phase_q == PH_FIRST && pci_byte_i < PCI_SINGLE) begin
              if (payload_1_i != NEG_RESPONSE) begin
                lane_cnt  = byte_n;
                job.tails = 2'd1;
                job.tail0 = KIND_DONE;
                job.lines = ONE_LINE;
                phase_d   = PH_IDLE;
              end
            end else if (phase_q == PH_FIRST && pci_byte_i[7:4] == PCI_FIRST) begin
              total_d   = first_len;
              lane_cnt  = byte_n;
              elapsed_d = '0;
              fib_d     = '0;
              wpos_d    = FRAME_STEP;
              job.tail0 = KIND_FLOW;
              if (first_len <= FIRST_BYTES) begin
                remaining_d = '0;
                job.tails   = 2'd2;
                job.tail1   = KIND_DONE;
                job.lines   = ONE_LINE;
                phase_d     = PH_IDLE;
              end else begin
                remaining_d = first_len - FIRST_BYTES;
                job.tails   = 2'd1;
                phase_d     = PH_CONSEC;
              end
            end else if (phase_q == PH_CONSEC && pci_byte_i[7:4] == PCI_CONSEC) begin
              if (wpos_q < POS_LIMIT) begin
                lane_cnt  = byte_n;
                lane_base = wpos_q[IDX_W-1:0];
                wpos_d    = wpos_q + FRAME_STEP;
              end
              remaining_d = rem_sub;
              fib_d       = blk_hit ? '0 : blk_cnt;
              if (rem_sub == '0) begin
                job.tails = 2'd1;
                job.tail0 = KIND_DONE;
                job.lines = lines_total;
                phase_d   = PH_IDLE;
              end else if (blk_hit) begin
                job.tails = 2'd1;
                job.tail0 = KIND_FLOW;
              end
            end else begin
              phase_d = phase_q;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
    job.n = lane_cnt;
  end

  assign load = accept && ((lane_cnt != '0) || (job.tails != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remaining_q <= '0;
      wpos_q      <= '0;
      fib_q       <= '0;
      elapsed_q   <= '0;
      total_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      wpos_q      <= wpos_d;
      fib_q       <= fib_d;
      elapsed_q   <= elapsed_d;
      total_q     <= total_d;
    end
  end

  isotp_result_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .lanes_i      (lanes),
    .job_i        (job),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .byte_index_o (byte_index_o),
    .byte_value_o (byte_value_o),
    .line_count_o (line_count_o),
    .last_o       (last_o),
    .status_o     (merge_st)
  );

endmodule

@@ hdl/isotp_byte_lane.sv @@
// ----------------------------------------------------------------------------
// ISO-TP byte lane
// Decides whether one payload byte of a frame is written and where.
// ----------------------------------------------------------------------------
module isotp_byte_lane import isotp_pkg::*; (
  input  logic [CNT_W-1:0] lane_num_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [IDX_W-1:0] base_i,
  input  logic [7:0]       byte_i,
  output lane_t            lane_o
);

  assign lane_o.en  = lane_num_i < count_i;
  assign lane_o.idx = base_i + IDX_W'(lane_num_i);
  assign lane_o.val = byte_i;

endmodule

@@ hdl/isotp_result_merge.sv @@
// ----------------------------------------------------------------------------
// ISO-TP result merge
// Holds the lane results and trailing reports of one word and hands them
// out one result a cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_top_assert.svh"

module isotp_result_merge import isotp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lane_t              lanes_i [LANES],
  input  job_t               job_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [IDX_W-1:0]   byte_index_o,
  output logic [7:0]         byte_value_o,
  output logic [LINES_W-1:0] line_count_o,
  output logic               last_o,
  output merge_st_t          status_o
);

  logic             active_q, active_d;
  logic [TOT_W-1:0] ptr_q, ptr_d;
  job_t             job_q;
  lane_t            lanes_q [LANES];

  logic [TOT_W-1:0] cur_total;
  logic [TOT_W-1:0] load_total;
  logic [TOT_W-1:0] tail_sel;
  logic             cur_last;
  kind_e            tail_kind;
  lane_t            cur_lane;

  assign cur_total  = TOT_W'(job_q.n) + TOT_W'(job_q.tails);
  assign load_total = TOT_W'(job_i.n) + TOT_W'(job_i.tails);
  assign cur_last   = ptr_q == (cur_total - TOT_W'(1));
  assign tail_sel   = ptr_q - TOT_W'(job_q.n);
  assign tail_kind  = tail_sel[0] ? job_q.tail1 : job_q.tail0;
  assign cur_lane   = lanes_q[ptr_q[CNT_W-1:0]];

  always_comb begin
    if (ptr_q < TOT_W'(job_q.n)) begin
      kind_o       = KIND_DATA;
      byte_index_o = cur_lane.idx;
      byte_value_o = cur_lane.val;
      line_count_o = '0;
    end else begin
      kind_o       = tail_kind;
      byte_index_o = '0;
      byte_value_o = '0;
      line_count_o = (tail_kind == KIND_DONE) ? job_q.lines : '0;
    end
  end

  assign out_valid_o     = active_q;
  assign last_o          = cur_last;
  assign status_o.active = active_q;
  assign status_o.last   = cur_last;

  always_comb begin
    active_d = active_q;
    ptr_d    = ptr_q;
    if (load_i) begin
      active_d = 1'b1;
      ptr_d    = '0;
    end else if (active_q && out_ready_i) begin
      if (cur_last) begin
        active_d = 1'b0;
      end else begin
        ptr_d = ptr_q + TOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (load_i) begin
      job_q   <= job_i;
      lanes_q <= lanes_i;
    end
  end

  `ISOTP_ASSERT_IMPL(a_load_when_free, load_i, !active_q || (out_ready_i && cur_last))
  `ISOTP_ASSERT_IMPL(a_load_nonempty, load_i, load_total != '0)
  `ISOTP_ASSERT_IMPL(a_ptr_in_range, active_q, ptr_q < cur_total)
  `ISOTP_ASSERT_IMPL(a_data_lane_en, active_q && (ptr_q < TOT_W'(job_q.n)), cur_lane.en)
  `ISOTP_ASSERT_NEXT(a_drain_idle, active_q && out_ready_i && cur_last && !load_i, !active_q)

endmodule

@@ verif/tb_isotp_receive_reassembler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler testbench
// Sends start, tick and frame words through the valid/ready input and checks
// every byte write, flow control request, completion and timeout that comes
// out. A behavioral copy of the reassembler runs alongside the block and
// predicts each result. A short table of hand-picked words comes first:
// ignored frames, single, first and consecutive frames, and the largest and
// smallest lengths. Random transfers follow under several register settings,
// and the extremes are among them. Both sides idle at random, and the result
// side holds off once for a long stretch. Registers are written over the
// APB-style port and read back.
// ----------------------------------------------------------------------------
module tb_isotp_receive_reassembler_top;
  import isotp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PRESS_AT       = 75;
  localparam int PRESS_CYCLES   = 400;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [3:0] PCI_SF        = 4'h0;
  localparam logic [3:0] PCI_FLOW_CTRL = 4'h3;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] id;
    logic [3:0]      len;
    logic [7:0]      pci;
    logic [6:0][7:0] pay;
  } frame_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         val;
    logic [LINES_W-1:0] lines;
    logic               last;
  } result_t;

  typedef struct packed {
    frame_word_t        w;
    logic               chk;
    kind_e              kind;
    logic [LINES_W-1:0] lines;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  frame_word_t        in_word = '0;
  logic               row_chk = 1'b0;
  kind_e              row_kind = KIND_DATA;
  logic [LINES_W-1:0] row_lines = '0;

  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [1:0]         kind_o;
  logic [IDX_W-1:0]   byte_index_o;
  logic [7:0]         byte_value_o;
  logic [LINES_W-1:0] line_count_o;
  logic               last_o;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // reassembler copy: registers and transfer state
  logic [ID_W-1:0]   cfg_id  = RESET_RESPONSE_ID;
  logic [BS_W-1:0]   cfg_bs  = RESET_BLOCK_SIZE;
  logic [TICK_W-1:0] cfg_tmo = RESET_TIMEOUT;
  phase_e            rx_phase = PH_IDLE;
  logic [12:0]       rem_bytes = '0;
  logic [12:0]       wr_pos = '0;
  logic [7:0]        blk_cnt = '0;
  logic [15:0]       ticks = '0;
  logic [11:0]       tot_len = '0;

  result_t   due_results[$];
  plan_row_t plan[$];

  bit idle_on = 1'b1;
  int words_in = 0;
  int results_out = 0;
  int failures = 0;
  int counted = 0;
  int settings = 0;
  int n_done = 0;
  int n_flow = 0;
  int n_tmo = 0;
  int stall_cycles = 0;

  isotp_receive_reassembler_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .mode_i         (in_word.mode),
    .can_id_i       (in_word.id),
    .frame_length_i (in_word.len),
    .pci_byte_i     (in_word.pci),
    .payload_1_i    (in_word.pay[0]),
    .payload_2_i    (in_word.pay[1]),
    .payload_3_i    (in_word.pay[2]),
    .payload_4_i    (in_word.pay[3]),
    .payload_5_i    (in_word.pay[4]),
    .payload_6_i    (in_word.pay[5]),
    .payload_7_i    (in_word.pay[6]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .kind_o         (kind_o),
    .byte_index_o   (byte_index_o),
    .byte_value_o   (byte_value_o),
    .line_count_o   (line_count_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void put_result(input kind_e kind, input logic [12:0] idx,
                                     input logic [7:0] val, input int lines);
    result_t r;
    r.kind  = kind;
    r.idx   = idx[IDX_W-1:0];
    r.val   = val;
    r.lines = LINES_W'(lines);
    r.last  = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void put_payload(input frame_word_t w, input logic [12:0] base);
    for (int i = 0; i < ((w.len < 7) ? int'(w.len) : 7); i++) begin
      put_result(KIND_DATA, base + 13'(i), w.pay[i], 0);
    end
  endfunction

  function automatic int reassemble(input frame_word_t w);
    int          first;
    int          lim;
    logic [12:0] used;
    logic [7:0]  cnt;
    logic        hit;
    result_t     r;
    first = due_results.size();
    case (w.mode)
      MODE_START: begin
        rx_phase  = PH_FIRST;
        rem_bytes = '0;
        wr_pos    = '0;
        blk_cnt   = '0;
        ticks     = '0;
        tot_len   = '0;
      end
      MODE_TICK: begin
        if (rx_phase != PH_IDLE) begin
          lim   = (cfg_tmo == 0) ? 1 : int'(cfg_tmo);
          ticks = ticks + 16'd1;
          if (int'(ticks) >= lim) begin
            put_result(KIND_TIMEOUT, '0, '0, 0);
            rx_phase = PH_IDLE;
          end
        end
      end
      MODE_FRAME: begin
        if (w.id == cfg_id) begin
          if (rx_phase == PH_FIRST && w.pci < PCI_SINGLE) begin
            if (w.pay[0] != NEG_RESPONSE) begin
              put_payload(w, '0);
              put_result(KIND_DONE, '0, '0, 1);
              rx_phase = PH_IDLE;
            end
          end else if (rx_phase == PH_FIRST && w.pci[7:4] == PCI_FIRST) begin
            tot_len = {w.pci[3:0], w.pay[0]};
            put_payload(w, '0);
            put_result(KIND_FLOW, '0, '0, 0);
            ticks   = '0;
            blk_cnt = '0;
            wr_pos  = 13'd7;
            if (tot_len <= 12'd6) begin
              rem_bytes = '0;
              put_result(KIND_DONE, '0, '0, (int'(tot_len) + 7) / 7);
              rx_phase = PH_IDLE;
            end else begin
              rem_bytes = 13'(tot_len) - 13'd6;
              rx_phase  = PH_CONSEC;
            end
          end else if (rx_phase == PH_CONSEC && w.pci[7:4] == PCI_CONSEC) begin
            used = (w.len == 0) ? 13'd0 : (w.len > 8) ? 13'd7 : 13'(w.len) - 13'd1;
            if (int'(wr_pos) < BUFFER_BYTES - 6) begin
              put_payload(w, wr_pos);
              wr_pos = wr_pos + 13'd7;
            end
            rem_bytes = (rem_bytes > used) ? rem_bytes - used : 13'd0;
            cnt       = blk_cnt + 8'd1;
            hit       = (cfg_bs == 0) ? (cnt == 0) : (cnt >= cfg_bs);
            blk_cnt   = hit ? 8'd0 : cnt;
            if (rem_bytes == 0) begin
              put_result(KIND_DONE, '0, '0, (int'(tot_len) + 7) / 7);
              rx_phase = PH_IDLE;
            end else if (hit) begin
              put_result(KIND_FLOW, '0, '0, 0);
            end
          end
        end
      end
      default: ;
    endcase
    if (due_results.size() > first) begin
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
    return due_results.size() - first;
  endfunction

  always @(posedge clk_i) begin
    int      n;
    bit      moved;
    result_t got;
    result_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid && in_ready_o) begin
        moved = 1'b1;
        words_in++;
        n = reassemble(in_word);
        if (row_chk && (n == 0 || due_results[$].kind != row_kind ||
                        due_results[$].lines != row_lines)) begin
          $display("%0t: table row %0d expected kind=%0d lines=%0d, predicted %0d results",
                   $time, words_in, row_kind, row_lines, n);
          failures++;
        end
      end
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        results_out++;
        got = {kind_o, byte_index_o, byte_value_o, line_count_o, last_o};
        case (got.kind)
          KIND_DONE:    n_done++;
          KIND_FLOW:    n_flow++;
          KIND_TIMEOUT: n_tmo++;
          default: ;
        endcase
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d idx=%0d val=%h lines=%0d last=%0b",
                   $time, got.kind, got.idx, got.val, got.lines, got.last);
          failures++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d idx=%0d val=%h lines=%0d last=%0b",
                     $time, want.kind, want.idx, want.val, want.lines, want.last,
                     " actual kind=%0d idx=%0d val=%h lines=%0d last=%0b",
                     got.kind, got.idx, got.val, got.lines, got.last);
            failures++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, due_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit pressed;
    pressed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressed && words_in >= PRESS_AT) begin
        // hold off results so the block backs up into its input
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (PRESS_CYCLES) @(posedge clk_i);
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < 15);
    end
  end

  function automatic void add(input logic [1:0] mode, input logic [3:0] len,
                              input logic [7:0] pci, input logic [7:0] p1,
                              input logic [7:0] fill, input logic chk = 1'b0,
                              input kind_e kind = KIND_DATA, input int lines = 0,
                              input logic [ID_W-1:0] id = RESET_RESPONSE_ID);
    plan_row_t r;
    r.w.mode  = mode;
    r.w.id    = id;
    r.w.len   = len;
    r.w.pci   = pci;
    r.w.pay   = {{6{fill}}, p1};
    r.chk     = chk;
    r.kind    = kind;
    r.lines   = LINES_W'(lines);
    plan.push_back(r);
  endfunction

  function automatic frame_word_t mk(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                     input logic [3:0] len, input logic [7:0] pci);
    frame_word_t w;
    w.mode = mode;
    w.id   = id;
    w.len  = len;
    w.pci  = pci;
    w.pay  = 56'({$urandom(), $urandom()});
    return w;
  endfunction

  task automatic push_word(input frame_word_t w, input logic chk = 1'b0,
                           input kind_e kind = KIND_DATA,
                           input logic [LINES_W-1:0] lines = '0);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_word   <= w;
    row_chk   <= chk;
    row_kind  <= kind;
    row_lines <= lines;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_RESPONSE_ID) ? 32'h7FF : (idx == REG_BLOCK_SIZE) ? 32'hFF : 32'hFFFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d readback expected %h actual %h",
               $time, idx, value & mask, prdata & mask);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RESPONSE_ID: cfg_id  = value[ID_W-1:0];
      REG_BLOCK_SIZE:  cfg_bs  = value[BS_W-1:0];
      default:         cfg_tmo = value[TICK_W-1:0];
    endcase
  endtask

  task automatic set_config(input logic [ID_W-1:0] id, input logic [BS_W-1:0] bs,
                            input logic [TICK_W-1:0] tmo);
    write_reg(REG_RESPONSE_ID, 32'(id));
    write_reg(REG_BLOCK_SIZE, 32'(bs));
    write_reg(REG_TIMEOUT, 32'(tmo));
    settings++;
  endtask

  task automatic noise();
    frame_word_t w;
    w = mk(MODE_FRAME, ID_W'($urandom), 4'($urandom_range(0, 8)), 8'($urandom));
    case ($urandom_range(0, 4))
      0: w.mode = MODE_TICK;
      1: w.mode = MODE_UNUSED;
      2: w.id = cfg_id;
      3: begin
        w.id  = cfg_id;
        w.pci = {PCI_FLOW_CTRL, w.pci[3:0]};
      end
      default: ;
    endcase
    push_word(w);
  endtask

  task automatic deliver(input frame_word_t w, input bit noisy);
    if (noisy && $urandom_range(0, 99) < 12) noise();
    push_word(w);
    counted++;
  endtask

  task automatic random_transfer(input int total, input int cap, input bit noisy);
    frame_word_t w;
    int          left;
    int          sent;
    int          r;
    deliver(mk(MODE_START, ID_W'($urandom), '0, '0), noisy);
    if (total < 0) begin
      w = mk(MODE_FRAME, cfg_id, 4'($urandom_range(0, 8)), {PCI_SF, 4'($urandom)});
      if ($urandom_range(0, 4) == 0) w.pay[0] = NEG_RESPONSE;
      deliver(w, noisy);
    end else begin
      w = mk(MODE_FRAME, cfg_id, 4'd8, {PCI_FIRST, 4'(total >> 8)});
      w.pay[0] = 8'(total);
      deliver(w, noisy);
      left = total - 6;
      sent = 0;
      while (left > 0 && sent < cap) begin
        r = $urandom_range(0, 99);
        w = mk(MODE_FRAME, cfg_id,
               (r < 75) ? 4'd8 : (r < 95) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15)),
               {PCI_CONSEC, 4'(sent + 1)});
        deliver(w, noisy);
        left -= (w.len == 0) ? 0 : (w.len > 8) ? 7 : int'(w.len) - 1;
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int target);
    int goal;
    int r;
    goal = counted + target;
    while (counted < goal) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        random_transfer(-1, 0, 1'b1);
      end else if (r < 25) begin
        // broken sequence: abandon after a few frames, or send frames before the first frame
        if ($urandom_range(0, 1) == 0) begin
          random_transfer($urandom_range(7, 4095), $urandom_range(0, 2), 1'b1);
        end else begin
          deliver(mk(MODE_START, cfg_id, '0, '0), 1'b1);
          deliver(mk(MODE_FRAME, cfg_id, 4'd8, {PCI_CONSEC, 4'($urandom)}), 1'b1);
        end
      end else begin
        random_transfer(($urandom_range(0, 9) == 0) ? $urandom_range(61, 100)
                                                     : $urandom_range(0, 60), 1000, 1'b1);
      end
    end
  endtask

  initial begin
    add(MODE_FRAME, 4'd8, {PCI_SF, 4'h7}, 8'h62, 8'hA5);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd8, {PCI_SF, 4'h3}, NEG_RESPONSE, 8'h78);
    add(MODE_FRAME, 4'd8, {PCI_SF, 4'h7}, 8'h62, 8'h00, 1'b0, KIND_DATA, 0, 11'h000);
    add(MODE_FRAME, 4'd8, {PCI_SF, 4'h7}, 8'hFF, 8'hFF, 1'b1, KIND_DONE, 1);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd0, {PCI_SF, 4'h0}, 8'h00, 8'h00, 1'b1, KIND_DONE, 1);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd8, {PCI_FIRST, 4'h0}, 8'h06, 8'h11, 1'b1, KIND_DONE, 1);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd3, {PCI_FIRST, 4'h0}, 8'h00, 8'h00, 1'b1, KIND_DONE, 1);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd8, {PCI_FIRST, 4'hF}, 8'hFF, 8'hFF, 1'b1, KIND_FLOW, 0);
    add(MODE_FRAME, 4'd8, {PCI_SF, 4'h7}, 8'h01, 8'h02);
    add(MODE_FRAME, 4'd8, {PCI_FIRST, 4'h0}, 8'h20, 8'h33);
    add(MODE_FRAME, 4'd8, {PCI_CONSEC, 4'h1}, 8'hFF, 8'hFF);
    add(MODE_FRAME, 4'd0, {PCI_CONSEC, 4'h2}, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd3, {PCI_FLOW_CTRL, 4'h0}, 8'h08, 8'h00);
    add(MODE_UNUSED, 4'd8, 8'hFF, 8'hFF, 8'hFF);
    add(MODE_TICK, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_START, 4'd0, 8'h00, 8'h00, 8'h00);
    add(MODE_FRAME, 4'd8, {PCI_FIRST, 4'h0}, 8'h14, 8'h5A);
    add(MODE_FRAME, 4'd8, {PCI_CONSEC, 4'h1}, 8'hC3, 8'h3C);
    add(MODE_FRAME, 4'd5, {PCI_CONSEC, 4'h2}, 8'h81, 8'h7E);
    add(MODE_FRAME, 4'd8, {PCI_CONSEC, 4'h3}, 8'h00, 8'hFF, 1'b1, KIND_DONE, 3);
    add(MODE_TICK, 4'd0, 8'h00, 8'h00, 8'h00);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) push_word(plan[i].w, plan[i].chk, plan[i].kind, plan[i].lines);
    settle();

    set_config(11'h000, 8'd1, 16'd1);
    random_phase(5);
    settle();

    idle_on = 1'b0;
    set_config(11'h7FF, 8'd255, 16'hFFFF);
    random_transfer(4095, 3, 1'b0);
    random_phase(4);
    settle();

    idle_on = 1'b1;
    set_config(ID_W'($urandom), 8'd0, 16'd0);
    random_phase(4);
    settle();

    set_config(ID_W'($urandom), BS_W'($urandom_range(2, 6)), TICK_W'($urandom_range(4, 8)));
    // run the write position past the end of the buffer
    idle_on = 1'b0;
    random_transfer(520, 1000, 1'b0);
    idle_on = 1'b1;
    random_transfer(30, 1, 1'b0);
    repeat (int'(cfg_tmo) + 1) push_word(mk(MODE_TICK, '0, '0, '0));
    random_phase(3);
    settle();

    $display("Run: %0d words in, %0d results out under %0d register settings",
             words_in, results_out, settings);
    $display("Reports seen: %0d completions, %0d flow control requests, %0d timeouts",
             n_done, n_flow, n_tmo);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
